// ----- design/ll1p_pkg.sv -----
package ll1p_pkg;

	localparam int NtCount = 52;
	localparam int SymW = 7;
	localparam int TokW = 5;
	localparam int ProdW = 6;
	localparam int MaxRhs = 11;
	localparam int LenW = 4;

	localparam logic [SymW-1:0] EndSym = 7'd77;
	localparam logic [SymW-1:0] StartSym = 7'd0;

	typedef enum logic [1:0] {
		ST_CONSUMED = 2'd0,
		ST_ACCEPTED = 2'd1,
		ST_SYNTAX = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		P_IDLE,
		P_INIT,
		P_READ,
		P_DECIDE,
		P_PUSH,
		P_DONE
	} pstate_t;

	localparam logic [TokW-1:0] TK_INT = 5'd0, TK_VOID = 5'd1, TK_ELSE = 5'd2, TK_IF = 5'd3,
		TK_WHILE = 5'd4, TK_RET = 5'd5, TK_ID = 5'd6, TK_NUM = 5'd7, TK_ASG = 5'd8,
		TK_ADD = 5'd9, TK_SUB = 5'd10, TK_MUL = 5'd11, TK_DIV = 5'd12, TK_LT = 5'd13,
		TK_LE = 5'd14, TK_GT = 5'd15, TK_GE = 5'd16, TK_EQ = 5'd17, TK_NE = 5'd18,
		TK_SEMI = 5'd19, TK_COMMA = 5'd20, TK_LP = 5'd21, TK_RP = 5'd22, TK_LB = 5'd23,
		TK_RB = 5'd24, TK_END = 5'd25;

	function automatic logic [SymW-1:0] ts(input logic [TokW-1:0] t);
		return SymW'(t) + SymW'(NtCount);
	endfunction

	function automatic logic [LenW-1:0] prod_len(input logic [ProdW-1:0] p);
		logic [LenW-1:0] r;
		r = '0;
		case (p)
			6'd0: r = 4'd0;
			6'd1, 6'd3, 6'd7, 6'd8, 6'd10, 6'd11, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
			6'd26, 6'd46, 6'd48: r = 4'd1;
			6'd2, 6'd6, 6'd12, 6'd13, 6'd17, 6'd18, 6'd30, 6'd37, 6'd40, 6'd43,
			6'd49: r = 4'd2;
			6'd4, 6'd5, 6'd14, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd44, 6'd45,
			6'd50: r = 4'd3;
			6'd15, 6'd16, 6'd25, 6'd38, 6'd39, 6'd41, 6'd42: r = 4'd4;
			6'd29, 6'd47: r = 4'd5;
			6'd9: r = 4'd7;
			6'd24, 6'd27: r = 4'd9;
			6'd28: r = 4'd11;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [SymW-1:0] prod_sym(input logic [ProdW-1:0] p,
			input logic [LenW-1:0] k);
		logic [SymW-1:0] s [MaxRhs];
		logic [SymW-1:0] r;
		for (int i = 0; i < MaxRhs; i++) s[i] = '0;
		case (p)
			6'd1: s[0] = 7'd1;
			6'd2: begin s[0] = 7'd3; s[1] = 7'd2; end
			6'd3: s[0] = 7'd1;
			6'd4: begin s[0] = ts(TK_INT); s[1] = ts(TK_ID); s[2] = 7'd4; end
			6'd5: begin s[0] = ts(TK_VOID); s[1] = ts(TK_ID); s[2] = 7'd6; end
			6'd6: begin s[0] = 7'd43; s[1] = 7'd5; end
			6'd7: s[0] = 7'd6;
			6'd8: s[0] = ts(TK_SEMI);
			6'd9: begin
				s[0] = 7'd36; s[1] = ts(TK_LP); s[2] = 7'd7; s[3] = 7'd37;
				s[4] = ts(TK_RP); s[5] = 7'd11; s[6] = 7'd39;
			end
			6'd10: s[0] = 7'd8;
			6'd11: s[0] = ts(TK_VOID);
			6'd12: begin s[0] = 7'd10; s[1] = 7'd9; end
			6'd13: begin s[0] = ts(TK_COMMA); s[1] = 7'd8; end
			6'd14: begin s[0] = ts(TK_INT); s[1] = ts(TK_ID); s[2] = 7'd43; end
			6'd15: begin s[0] = ts(TK_LB); s[1] = 7'd12; s[2] = 7'd14; s[3] = ts(TK_RB); end
			6'd16: begin s[0] = 7'd13; s[1] = 7'd43; s[2] = ts(TK_SEMI); s[3] = 7'd12; end
			6'd17: begin s[0] = ts(TK_INT); s[1] = ts(TK_ID); end
			6'd18: begin s[0] = 7'd16; s[1] = 7'd15; end
			6'd19: s[0] = 7'd14;
			6'd20: s[0] = 7'd21;
			6'd21: s[0] = 7'd20;
			6'd22: s[0] = 7'd18;
			6'd23: s[0] = 7'd17;
			6'd24: begin
				s[0] = 7'd44; s[1] = 7'd48; s[2] = ts(TK_ID); s[3] = 7'd48;
				s[4] = ts(TK_ASG); s[5] = 7'd23; s[6] = 7'd45; s[7] = 7'd51;
				s[8] = ts(TK_SEMI);
			end
			6'd25: begin s[0] = ts(TK_RET); s[1] = 7'd19; s[2] = 7'd38; s[3] = ts(TK_SEMI); end
			6'd26: s[0] = 7'd23;
			6'd27: begin
				s[0] = ts(TK_WHILE); s[1] = 7'd35; s[2] = ts(TK_LP); s[3] = 7'd44;
				s[4] = 7'd23; s[5] = 7'd46; s[6] = ts(TK_RP); s[7] = 7'd11; s[8] = 7'd47;
			end
			6'd28: begin
				s[0] = ts(TK_IF); s[1] = 7'd35; s[2] = ts(TK_LP); s[3] = 7'd44;
				s[4] = 7'd23; s[5] = 7'd46; s[6] = ts(TK_RP); s[7] = 7'd11;
				s[8] = 7'd40; s[9] = 7'd22; s[10] = 7'd42;
			end
			6'd29: begin
				s[0] = 7'd41; s[1] = ts(TK_ELSE); s[2] = 7'd35; s[3] = 7'd11; s[4] = 7'd40;
			end
			6'd30: begin s[0] = 7'd25; s[1] = 7'd24; end
			6'd31: begin s[0] = 7'd48; s[1] = ts(TK_LT); s[2] = 7'd23; end
			6'd32: begin s[0] = 7'd48; s[1] = ts(TK_LE); s[2] = 7'd23; end
			6'd33: begin s[0] = 7'd48; s[1] = ts(TK_GT); s[2] = 7'd23; end
			6'd34: begin s[0] = 7'd48; s[1] = ts(TK_GE); s[2] = 7'd23; end
			6'd35: begin s[0] = 7'd48; s[1] = ts(TK_EQ); s[2] = 7'd23; end
			6'd36: begin s[0] = 7'd48; s[1] = ts(TK_NE); s[2] = 7'd23; end
			6'd37: begin s[0] = 7'd27; s[1] = 7'd26; end
			6'd38: begin s[0] = 7'd48; s[1] = ts(TK_ADD); s[2] = 7'd25; s[3] = 7'd45; end
			6'd39: begin s[0] = 7'd48; s[1] = ts(TK_SUB); s[2] = 7'd25; s[3] = 7'd45; end
			6'd40: begin s[0] = 7'd29; s[1] = 7'd28; end
			6'd41: begin s[0] = 7'd48; s[1] = ts(TK_MUL); s[2] = 7'd27; s[3] = 7'd45; end
			6'd42: begin s[0] = 7'd48; s[1] = ts(TK_DIV); s[2] = 7'd27; s[3] = 7'd45; end
			6'd43: begin s[0] = 7'd48; s[1] = ts(TK_NUM); end
			6'd44: begin s[0] = ts(TK_LP); s[1] = 7'd23; s[2] = ts(TK_RP); end
			6'd45: begin s[0] = 7'd48; s[1] = ts(TK_ID); s[2] = 7'd30; end
			6'd46: s[0] = 7'd31;
			6'd47: begin
				s[0] = 7'd49; s[1] = ts(TK_LP); s[2] = 7'd33; s[3] = 7'd50; s[4] = ts(TK_RP);
			end
			6'd48: s[0] = 7'd33;
			6'd49: begin s[0] = 7'd23; s[1] = 7'd34; end
			6'd50: begin s[0] = 7'd50; s[1] = ts(TK_COMMA); s[2] = 7'd33; end
			default: s[0] = '0;
		endcase
		r = '0;
		for (int i = 0; i < MaxRhs; i++)
			if (k == LenW'(i)) r = s[i];
		return r;
	endfunction

	// prediction: valid flag in bit 6, production in bits 5:0
	function automatic logic [ProdW:0] predict(input logic [SymW-1:0] nt,
			input logic [TokW-1:0] t);
		logic [31:0] b;
		logic [31:0] mstmt, mexpr, mrel, mtail, madd, mmul;
		logic [ProdW:0] r;
		b = 32'd1 << t;
		mstmt = (32'd1 << TK_IF) | (32'd1 << TK_WHILE) | (32'd1 << TK_RET) | (32'd1 << TK_ID);
		mexpr = (32'd1 << TK_ID) | (32'd1 << TK_NUM) | (32'd1 << TK_LP);
		mrel = (32'd1 << TK_LT) | (32'd1 << TK_LE) | (32'd1 << TK_GT) | (32'd1 << TK_GE) |
			(32'd1 << TK_EQ) | (32'd1 << TK_NE);
		mtail = (32'd1 << TK_SEMI) | (32'd1 << TK_COMMA) | (32'd1 << TK_RP);
		madd = (32'd1 << TK_ADD) | (32'd1 << TK_SUB);
		mmul = (32'd1 << TK_MUL) | (32'd1 << TK_DIV);
		r = '0;
		case (nt)
			7'd0: if (t == TK_INT || t == TK_VOID) r = {1'b1, 6'd1};
			7'd1: if (t == TK_INT || t == TK_VOID) r = {1'b1, 6'd2};
			7'd2: begin
				if (t == TK_INT || t == TK_VOID) r = {1'b1, 6'd3};
				else if (t == TK_END) r = {1'b1, 6'd0};
			end
			7'd3: begin
				if (t == TK_INT) r = {1'b1, 6'd4};
				else if (t == TK_VOID) r = {1'b1, 6'd5};
			end
			7'd4: begin
				if (t == TK_SEMI) r = {1'b1, 6'd6};
				else if (t == TK_LP) r = {1'b1, 6'd7};
			end
			7'd5: if (t == TK_SEMI) r = {1'b1, 6'd8};
			7'd6: if (t == TK_LP) r = {1'b1, 6'd9};
			7'd7: begin
				if (t == TK_INT) r = {1'b1, 6'd10};
				else if (t == TK_VOID) r = {1'b1, 6'd11};
				else if (t == TK_RP) r = {1'b1, 6'd0};
			end
			7'd8: if (t == TK_INT) r = {1'b1, 6'd12};
			7'd9: begin
				if (t == TK_COMMA) r = {1'b1, 6'd13};
				else if (t == TK_RP) r = {1'b1, 6'd0};
			end
			7'd10: if (t == TK_INT) r = {1'b1, 6'd14};
			7'd11: if (t == TK_LB) r = {1'b1, 6'd15};
			7'd12: begin
				if (t == TK_INT) r = {1'b1, 6'd16};
				else if ((mstmt & b) != 0) r = {1'b1, 6'd0};
			end
			7'd13: if (t == TK_INT) r = {1'b1, 6'd17};
			7'd14: if ((mstmt & b) != 0) r = {1'b1, 6'd18};
			7'd15: begin
				if ((mstmt & b) != 0) r = {1'b1, 6'd19};
				else if (t == TK_RB) r = {1'b1, 6'd0};
			end
			7'd16: begin
				if (t == TK_IF) r = {1'b1, 6'd20};
				else if (t == TK_WHILE) r = {1'b1, 6'd21};
				else if (t == TK_RET) r = {1'b1, 6'd22};
				else if (t == TK_ID) r = {1'b1, 6'd23};
			end
			7'd17: if (t == TK_ID) r = {1'b1, 6'd24};
			7'd18: if (t == TK_RET) r = {1'b1, 6'd25};
			7'd19: begin
				if ((mexpr & b) != 0) r = {1'b1, 6'd26};
				else if (t == TK_SEMI) r = {1'b1, 6'd0};
			end
			7'd20: if (t == TK_WHILE) r = {1'b1, 6'd27};
			7'd21: if (t == TK_IF) r = {1'b1, 6'd28};
			7'd22: begin
				if (t == TK_ELSE) r = {1'b1, 6'd29};
				else if (((mstmt | (32'd1 << TK_RB)) & b) != 0) r = {1'b1, 6'd0};
			end
			7'd23: if ((mexpr & b) != 0) r = {1'b1, 6'd30};
			7'd24: begin
				if (t == TK_LT) r = {1'b1, 6'd31};
				else if (t == TK_LE) r = {1'b1, 6'd32};
				else if (t == TK_GT) r = {1'b1, 6'd33};
				else if (t == TK_GE) r = {1'b1, 6'd34};
				else if (t == TK_EQ) r = {1'b1, 6'd35};
				else if (t == TK_NE) r = {1'b1, 6'd36};
				else if ((mtail & b) != 0) r = {1'b1, 6'd0};
			end
			7'd25: if ((mexpr & b) != 0) r = {1'b1, 6'd37};
			7'd26: begin
				if (t == TK_ADD) r = {1'b1, 6'd38};
				else if (t == TK_SUB) r = {1'b1, 6'd39};
				else if (((mrel | mtail) & b) != 0) r = {1'b1, 6'd0};
			end
			7'd27: if ((mexpr & b) != 0) r = {1'b1, 6'd40};
			7'd28: begin
				if (t == TK_MUL) r = {1'b1, 6'd41};
				else if (t == TK_DIV) r = {1'b1, 6'd42};
				else if (((madd | mrel | mtail) & b) != 0) r = {1'b1, 6'd0};
			end
			7'd29: begin
				if (t == TK_ID) r = {1'b1, 6'd45};
				else if (t == TK_NUM) r = {1'b1, 6'd43};
				else if (t == TK_LP) r = {1'b1, 6'd44};
			end
			7'd30: begin
				if (((madd | mmul | mrel | mtail) & b) != 0) r = {1'b1, 6'd0};
				else if (t == TK_LP) r = {1'b1, 6'd46};
			end
			7'd31: if (t == TK_LP) r = {1'b1, 6'd47};
			7'd32: begin
				if ((mexpr & b) != 0) r = {1'b1, 6'd48};
				else if (t == TK_RP) r = {1'b1, 6'd0};
			end
			7'd33: if ((mexpr & b) != 0) r = {1'b1, 6'd49};
			7'd34: begin
				if (t == TK_COMMA) r = {1'b1, 6'd50};
				else if (t == TK_RP) r = {1'b1, 6'd0};
			end
			7'd35: if (t == TK_LP || t == TK_LB) r = {1'b1, 6'd0};
			7'd36: if (t == TK_LP) r = {1'b1, 6'd0};
			7'd37: if (t == TK_RP) r = {1'b1, 6'd0};
			7'd38: if (t == TK_SEMI) r = {1'b1, 6'd0};
			7'd39: if (t == TK_INT || t == TK_VOID || t == TK_END) r = {1'b1, 6'd0};
			7'd40: if (((mstmt | (32'd1 << TK_RB) | (32'd1 << TK_ELSE)) & b) != 0)
				r = {1'b1, 6'd0};
			7'd41: if (t == TK_ELSE) r = {1'b1, 6'd0};
			7'd42: if (((mstmt | (32'd1 << TK_RB)) & b) != 0) r = {1'b1, 6'd0};
			7'd43: if ((mtail & b) != 0) r = {1'b1, 6'd0};
			7'd44: if ((mexpr & b) != 0) r = {1'b1, 6'd0};
			7'd45: if (((madd | mrel | mtail) & b) != 0) r = {1'b1, 6'd0};
			7'd46: if (t == TK_RP) r = {1'b1, 6'd0};
			7'd47: if (((mstmt | (32'd1 << TK_RP) | (32'd1 << TK_RB)) & b) != 0)
				r = {1'b1, 6'd0};
			7'd48: if ((((32'd1 << TK_ID) | (32'd1 << TK_NUM) | (32'd1 << TK_ASG) |
					madd | mmul | mrel) & b) != 0) r = {1'b1, 6'd0};
			7'd49: if (t == TK_LP) r = {1'b1, 6'd0};
			7'd50: if (t == TK_COMMA || t == TK_RP) r = {1'b1, 6'd0};
			7'd51: if (((madd | mmul | mrel | mtail) & b) != 0) r = {1'b1, 6'd0};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/ll1p_if.sv -----
interface ll1p_if #(parameter int W = 5);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- design/ll1p_stack.sv -----
module ll1p_stack #(
	parameter int Depth = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [ll1p_pkg::SymW-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [ll1p_pkg::SymW-1:0] rdata
);
	logic [ll1p_pkg::SymW-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- design/ll1_table_driven_parser_unit.sv -----
// Steps: take a token in IDLE, read the stack top in READ and test it in DECIDE; a
// nonterminal is replaced by its production (pushed in PUSH, then READ again), while a
// terminal or an error goes to DONE. One stack memory port pair sets the pace.
// One token at a time: tok_in.ready is low while busy. Result is held in an
// output register until taken. Reset: asynchronous, stack level 2; after reset and
// after each accept or error the two bottom entries are rewritten in INIT (end marker, then start symbol).
module ll1_table_driven_parser_unit #(
	parameter int STACK_DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	ll1p_if.sink tok_in,
	ll1p_if.source res_out
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PW = $clog2(STACK_DEPTH + 1) + 1;

	ll1p_pkg::pstate_t state_q, state_d;
	logic [PW-1:0] sp_q;
	logic [4:0] tok_q;
	logic [ll1p_pkg::ProdW-1:0] prod_q;
	logic [ll1p_pkg::LenW-1:0] k_q;
	logic init_ph_q;
	logic [1:0] status_q;
	logic [6:0] level_q;
	logic out_v_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [ll1p_pkg::SymW-1:0] wdata, top;
	logic [ll1p_pkg::ProdW:0] pr;
	logic [ll1p_pkg::LenW-1:0] plen;
	logic [PW-1:0] sp_dec;

	ll1p_stack #(.Depth(STACK_DEPTH), .AW(AW)) u_stack (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(top)
	);

	assign sp_dec = sp_q - PW'(1);
	assign raddr = sp_dec[AW-1:0];
	assign pr = ll1p_pkg::predict(top, tok_q);
	assign plen = ll1p_pkg::prod_len(pr[ll1p_pkg::ProdW-1:0]);

	assign tok_in.ready = (state_q == ll1p_pkg::P_IDLE) && !out_v_q;
	assign res_out.valid = out_v_q;
	assign res_out.data = {status_q, level_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ll1p_pkg::P_IDLE: if (tok_in.valid && tok_in.ready) state_d = ll1p_pkg::P_READ;
			ll1p_pkg::P_INIT: if (init_ph_q) state_d = ll1p_pkg::P_IDLE;
			ll1p_pkg::P_READ: state_d = ll1p_pkg::P_DECIDE;
			ll1p_pkg::P_DECIDE: begin
				if (top >= ll1p_pkg::SymW'(ll1p_pkg::NtCount)) state_d = ll1p_pkg::P_DONE;
				else if (!pr[ll1p_pkg::ProdW]) state_d = ll1p_pkg::P_DONE;
				else if (32'(sp_dec) + 32'(plen) > STACK_DEPTH) state_d = ll1p_pkg::P_DONE;
				else if (plen == '0) state_d = ll1p_pkg::P_READ;
				else state_d = ll1p_pkg::P_PUSH;
			end
			ll1p_pkg::P_PUSH: if (k_q == ll1p_pkg::LenW'(0)) state_d = ll1p_pkg::P_READ;
			ll1p_pkg::P_DONE: state_d = (status_q != ll1p_pkg::ST_CONSUMED) ?
				ll1p_pkg::P_INIT : ll1p_pkg::P_IDLE;
			default: state_d = ll1p_pkg::P_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = sp_q[AW-1:0];
		wdata = ll1p_pkg::prod_sym(prod_q, k_q);
		case (state_q)
			ll1p_pkg::P_INIT: begin
				we = 1'b1;
				waddr = init_ph_q ? AW'(1) : AW'(0);
				wdata = init_ph_q ? ll1p_pkg::StartSym : ll1p_pkg::EndSym;
			end
			ll1p_pkg::P_PUSH: we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ll1p_pkg::P_INIT;
			sp_q <= PW'(2);
			init_ph_q <= 1'b0;
			out_v_q <= 1'b0;
			status_q <= ll1p_pkg::ST_CONSUMED;
			level_q <= '0;
			tok_q <= '0;
			prod_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			if (res_out.valid && res_out.ready) out_v_q <= 1'b0;
			case (state_q)
				ll1p_pkg::P_IDLE: begin
					init_ph_q <= 1'b0;
					if (tok_in.valid && tok_in.ready) tok_q <= tok_in.data;
				end
				ll1p_pkg::P_INIT: init_ph_q <= 1'b1;
				ll1p_pkg::P_DECIDE: begin
					if (top >= ll1p_pkg::SymW'(ll1p_pkg::NtCount)) begin
						if (top == ll1p_pkg::ts(tok_q)) begin
							sp_q <= sp_dec;
							status_q <= (sp_dec == '0) ? ll1p_pkg::ST_ACCEPTED
								: ll1p_pkg::ST_CONSUMED;
						end else status_q <= ll1p_pkg::ST_SYNTAX;
					end else if (!pr[ll1p_pkg::ProdW]) begin
						status_q <= ll1p_pkg::ST_SYNTAX;
					end else if (32'(sp_dec) + 32'(plen) > STACK_DEPTH) begin
						status_q <= ll1p_pkg::ST_OVERFLOW;
					end else begin
						sp_q <= sp_dec;
						prod_q <= pr[ll1p_pkg::ProdW-1:0];
						k_q <= plen - ll1p_pkg::LenW'(1);
					end
				end
				ll1p_pkg::P_PUSH: begin
					sp_q <= sp_q + PW'(1);
					k_q <= k_q - ll1p_pkg::LenW'(1);
				end
				ll1p_pkg::P_DONE: begin
					out_v_q <= 1'b1;
					init_ph_q <= 1'b0;
					if (status_q != ll1p_pkg::ST_CONSUMED) begin
						sp_q <= PW'(2);
						level_q <= 7'd2;
					end else level_q <= 7'(sp_q);
				end
				default: init_ph_q <= init_ph_q;
			endcase
		end
	end
endmodule
